// ===== rtl/llod_pkg.sv =====
// Shared constants, codes and control structs of the least-loaded operator dispatcher.
`default_nettype none

package llod_pkg;

  localparam int DEF_NUM_THREADS = 4;
  localparam int DEF_NUM_SLOTS   = 64;

  localparam int CFG_REGS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int OPC_W      = 8;
  localparam int LOAD_W     = 7;
  localparam int OWNER_W    = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int STATUS_W   = 2;
  localparam int THR_IDX_W  = 3;
  localparam int WORD_W     = 32;
  localparam int WORD_LOG   = 5;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_THREAD  = 2'd1,
    ST_NO_SLOT    = 2'd2,
    ST_NOT_ACTIVE = 2'd3
  } status_t;

  typedef struct packed {
    logic                 inc;
    logic                 dec;
    logic [THR_IDX_W-1:0] thread;
  } load_upd_t;

  typedef struct packed {
    logic               take;
    logic               free;
    logic [OWNER_W-1:0] owner;
  } slot_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/llod_thread_sel.sv =====
// Opcode registers, per-thread load counters and least-loaded thread selection.
`default_nettype none

module llod_thread_sel import llod_pkg::*; #(
  parameter int NUM_THREADS = DEF_NUM_THREADS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [OPC_W-1:0]     cfg_wdata,
  input  logic [OPC_W-1:0]     req_opcode,
  input  load_upd_t            upd,
  output logic                 found,
  output logic [THR_IDX_W-1:0] best
);

  localparam int THR_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  logic [OPC_W-1:0]  cfg_opcode [CFG_REGS];
  logic [OPC_W-1:0]  thr_opcode [NUM_THREADS];
  logic [LOAD_W-1:0] load       [NUM_THREADS];
  logic [LOAD_W-1:0] best_load;
  logic [THR_W-1:0]  upd_idx;

  assign upd_idx = THR_W'(upd.thread);

  for (genvar g = 0; g < NUM_THREADS; g++) begin : g_opc
    if (g < CFG_REGS) begin : g_reg
      assign thr_opcode[g] = cfg_opcode[g];
    end else begin : g_none
      assign thr_opcode[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        cfg_opcode[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_opcode[cfg_idx] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_THREADS; i++) begin
        load[i] <= '0;
      end
    end else begin
      if (upd.inc && load[upd_idx] != LOAD_MAX) begin
        load[upd_idx] <= load[upd_idx] + LOAD_W'(1);
      end
      if (upd.dec && load[upd_idx] != '0) begin
        load[upd_idx] <= load[upd_idx] - LOAD_W'(1);
      end
    end
  end

  always_comb begin
    found     = 1'b0;
    best      = '0;
    best_load = '0;
    for (int t = 0; t < NUM_THREADS; t++) begin
      if (req_opcode != '0 && thr_opcode[t] == req_opcode &&
          (!found || load[t] < best_load)) begin
        found     = 1'b1;
        best      = THR_IDX_W'(t);
        best_load = load[t];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/llod_slot_map.sv =====
// Slot busy bitmap memory with row-full summary and slot owner memory.
`default_nettype none

module llod_slot_map import llod_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  start_alloc,
  input  logic [SLOT_OUT_W-1:0] release_slot,
  input  slot_cmd_t             cmd,
  output logic                  any_free,
  output logic [SLOT_OUT_W-1:0] found_slot,
  output logic                  rel_busy,
  output logic [OWNER_W-1:0]    rel_owner
);

  localparam int NUM_ROWS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int SLOT_W   = $clog2(NUM_SLOTS);

  logic [WORD_W-1:0]  busy_mem  [NUM_ROWS];
  logic [OWNER_W-1:0] owner_mem [NUM_SLOTS];

  logic [NUM_ROWS-1:0] row_valid;
  logic [NUM_ROWS-1:0] row_full;

  logic [WORD_W-1:0]   rd_word;
  logic [OWNER_W-1:0]  rd_owner;
  logic                rd_ok;
  logic [ROW_W-1:0]    row;
  logic                free_seen;
  logic                in_range;
  logic [WORD_LOG-1:0] rel_bit;

  logic [ROW_W-1:0]          free_row;
  logic                      free_any;
  logic [ROW_W-1:0]          rd_addr;
  logic [WORD_W-1:0]         pad;
  logic [WORD_W-1:0]         word_raw;
  logic [WORD_W-1:0]         word_eff;
  logic [WORD_W-1:0]         new_word;
  logic [WORD_LOG-1:0]       fz_bit;
  logic [ROW_W+WORD_LOG-1:0] slot_full;

  always_comb begin
    free_any = 1'b0;
    free_row = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (!row_full[r]) begin
        free_any = 1'b1;
        free_row = ROW_W'(r);
      end
    end
  end

  assign rd_addr = start_alloc ? free_row : ROW_W'(release_slot >> WORD_LOG);

  always_ff @(posedge clk) begin
    if (start) begin
      rd_word  <= busy_mem[rd_addr];
      rd_owner <= owner_mem[SLOT_W'(release_slot)];
      rd_ok    <= row_valid[rd_addr];
      row      <= rd_addr;
      free_seen <= free_any;
      in_range <= int'(release_slot) < NUM_SLOTS;
      rel_bit  <= release_slot[WORD_LOG-1:0];
    end
    if (cmd.take || cmd.free) begin
      busy_mem[row] <= new_word;
    end
    if (cmd.take) begin
      owner_mem[SLOT_W'(slot_full)] <= cmd.owner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
    end else if (cmd.take || cmd.free) begin
      row_valid[row] <= 1'b1;
      row_full[row]  <= &(new_word | pad);
    end
  end

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      pad[b] = (int'(row) * WORD_W + b) >= NUM_SLOTS;
    end
  end

  assign word_raw = rd_ok ? rd_word : '0;
  assign word_eff = word_raw | pad;

  always_comb begin
    fz_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word_eff[b]) begin
        fz_bit = WORD_LOG'(b);
      end
    end
  end

  assign slot_full = {row, fz_bit};
  assign new_word  = cmd.take ? (word_raw | (WORD_W'(1) << fz_bit))
                              : (word_raw & ~(WORD_W'(1) << rel_bit));

  assign any_free   = free_seen;
  assign found_slot = SLOT_OUT_W'(slot_full);
  assign rel_busy   = in_range && word_raw[rel_bit];
  assign rel_owner  = rd_owner;

endmodule

`default_nettype wire

// ===== rtl/least_loaded_operator_dispatcher.sv =====
// Top level of the least-loaded operator dispatcher: request sequencing and result register.
//
// Requests arrive as beats on the in channel (op, req_opcode, release_slot) and every
// request produces exactly one result beat on the out channel (status, thread_index,
// slot_index). An allocate picks the least-loaded thread whose opcode register matches
// req_opcode and takes the lowest free slot; a release frees a busy slot and lowers
// the load of its owner. Opcode registers are written through the cfg channel, which
// is always ready and must only be used while no request is in flight.
// A request is accepted while the slot bitmap row and owner entry are read into
// registers; the row is then updated and written back and the result is loaded
// into the output register. The block takes no new request until this
// read-then-write of the bitmap memory is done. If the receiver stalls, the result
// waits in the output register and the next request is still accepted; its
// write-back then holds until the output register is free.
// Reset clears the opcode registers, the thread loads and the row valid bits, so all
// slots read as free right away; no clearing pass is needed.
`default_nettype none

module least_loaded_operator_dispatcher import llod_pkg::*; #(
  parameter int NUM_THREADS = DEF_NUM_THREADS,
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [OPC_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [OPC_W-1:0]      req_opcode,
  input  logic [SLOT_OUT_W-1:0] release_slot,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [OWNER_W-1:0]    thread_index,
  output logic [SLOT_OUT_W-1:0] slot_index
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WORK = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic                 cur_op;
  logic                 found;
  logic [THR_IDX_W-1:0] best;
  logic                 sel_found;
  logic [THR_IDX_W-1:0] sel_best;

  logic                  any_free;
  logic [SLOT_OUT_W-1:0] found_slot;
  logic                  rel_busy;
  logic [OWNER_W-1:0]    rel_owner;
  logic [SLOT_OUT_W-1:0] rel_slot;

  logic      accept;
  logic      advance;
  logic      alloc_ok;
  logic      free_ok;
  slot_cmd_t cmd;
  load_upd_t upd;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign advance   = (state == S_WORK) && (!out_valid || out_ready);

  assign alloc_ok = (cur_op == OP_ALLOC) && found && any_free;
  assign free_ok  = (cur_op == OP_RELEASE) && rel_busy;

  assign cmd.take  = advance && alloc_ok;
  assign cmd.free  = advance && free_ok;
  assign cmd.owner = OWNER_W'(best);

  assign upd.inc    = cmd.take;
  assign upd.dec    = cmd.free && (int'(rel_owner) < NUM_THREADS);
  assign upd.thread = (cur_op == OP_ALLOC) ? best : THR_IDX_W'(rel_owner);

  llod_thread_sel #(
    .NUM_THREADS (NUM_THREADS)
  ) u_thread_sel (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .req_opcode (req_opcode),
    .upd        (upd),
    .found      (sel_found),
    .best       (sel_best)
  );

  llod_slot_map #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_map (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .start_alloc  (op == OP_ALLOC),
    .release_slot (release_slot),
    .cmd          (cmd),
    .any_free     (any_free),
    .found_slot   (found_slot),
    .rel_busy     (rel_busy),
    .rel_owner    (rel_owner)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (advance) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op   <= op;
      found    <= sel_found;
      best     <= sel_best;
      rel_slot <= release_slot;
    end
    if (advance) begin
      status       <= ST_OK;
      thread_index <= '0;
      slot_index   <= '0;
      priority if (cur_op == OP_ALLOC && !found) begin
        status <= ST_NO_THREAD;
      end else if (cur_op == OP_ALLOC && !any_free) begin
        status <= ST_NO_SLOT;
      end else if (cur_op == OP_ALLOC) begin
        thread_index <= OWNER_W'(best);
        slot_index   <= found_slot;
      end else if (!rel_busy) begin
        status <= ST_NOT_ACTIVE;
      end else begin
        thread_index <= rel_owner;
        slot_index   <= rel_slot;
      end
    end
  end

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted while a request was in flight");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WORK))
    else $error("result produced without a request in flight");

  a_fail_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> thread_index == '0 && slot_index == '0)
    else $error("failed request carries nonzero thread or slot");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register lost its one-hot code");

endmodule

`default_nettype wire

// ===== tb/llod_dispatch_checker.sv =====
// Checker for the dispatcher: tracks thread loads and slot ownership and compares every result beat.
`timescale 1ns / 1ps

module llod_dispatch_checker import llod_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [OPC_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     op,
  input  logic [OPC_W-1:0]         req_opcode,
  input  logic [SLOT_OUT_W-1:0]    release_slot,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STATUS_W-1:0]      status,
  input  logic [OWNER_W-1:0]       thread_index,
  input  logic [SLOT_OUT_W-1:0]    slot_index,
  output int                       mismatches,
  output int                       outstanding,
  output logic [DEF_NUM_SLOTS-1:0] busy_map,
  output int                       n_ok,
  output int                       n_no_thread,
  output int                       n_no_slot,
  output int                       n_not_active
);

  typedef struct packed {
    status_t               st;
    logic [OWNER_W-1:0]    thr;
    logic [SLOT_OUT_W-1:0] slot;
  } grant_t;

  logic [OPC_W-1:0]         thread_opc [DEF_NUM_THREADS];
  logic [LOAD_W-1:0]        load [DEF_NUM_THREADS];
  logic [DEF_NUM_SLOTS-1:0] busy;
  logic [OWNER_W-1:0]       owner [DEF_NUM_SLOTS];
  grant_t                   expected_grants [$];
  int                       errs = 0;
  int                       tally [4] = '{default: 0};

  function automatic grant_t dispatch_outcome(input logic o, input logic [OPC_W-1:0] opc,
                                              input logic [SLOT_OUT_W-1:0] rs);
    grant_t g;
    logic   hit;
    int     best;
    int     s;
    g.st   = ST_OK;
    g.thr  = '0;
    g.slot = '0;
    if (o == OP_ALLOC) begin
      hit  = 1'b0;
      best = 0;
      for (int t = 0; t < DEF_NUM_THREADS; t++) begin
        if (opc != '0 && thread_opc[t] == opc && (!hit || load[t] < load[best])) begin
          hit  = 1'b1;
          best = t;
        end
      end
      if (!hit) begin
        g.st = ST_NO_THREAD;
      end else begin
        s = 0;
        while (s < DEF_NUM_SLOTS && busy[s]) s++;
        if (s == DEF_NUM_SLOTS) begin
          g.st = ST_NO_SLOT;
        end else begin
          busy[s]  = 1'b1;
          owner[s] = OWNER_W'(best);
          if (load[best] != LOAD_MAX) load[best]++;
          g.thr  = OWNER_W'(best);
          g.slot = SLOT_OUT_W'(s);
        end
      end
    end else if (!busy[rs]) begin
      g.st = ST_NOT_ACTIVE;
    end else begin
      if (load[owner[rs]] != '0) load[owner[rs]]--;
      busy[rs] = 1'b0;
      g.thr    = owner[rs];
      g.slot   = rs;
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      thread_opc = '{default: '0};
      load       = '{default: '0};
      busy       = '0;
      expected_grants.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("ERROR: result beat with nothing pending: status=%0d thread=%0d slot=%0d",
                     status, thread_index, slot_index);
        end else begin
          want = expected_grants.pop_front();
          tally[want.st]++;
          if (status !== want.st || thread_index !== want.thr || slot_index !== want.slot) begin
            errs++;
            if (errs <= 10)
              $display("ERROR: expected status=%0d thread=%0d slot=%0d, got %0d %0d %0d",
                       want.st, want.thr, want.slot, status, thread_index, slot_index);
          end
        end
      end
      if (cfg_valid && cfg_ready) thread_opc[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        expected_grants.push_back(dispatch_outcome(op, req_opcode, release_slot));
    end
    mismatches   <= errs;
    outstanding  <= expected_grants.size();
    busy_map     <= busy;
    n_ok         <= tally[ST_OK];
    n_no_thread  <= tally[ST_NO_THREAD];
    n_no_slot    <= tally[ST_NO_SLOT];
    n_not_active <= tally[ST_NOT_ACTIVE];
  end

endmodule

// ===== tb/least_loaded_operator_dispatcher_test.sv =====
// Testbench top for the dispatcher: drives requests and opcode writes and reports the verdict.
`timescale 1ns / 1ps

module least_loaded_operator_dispatcher_test;
  import llod_pkg::*;

  localparam int REG_THREAD0_OPCODE = 0;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index    = '0;
  logic [OPC_W-1:0]         cfg_data     = '0;
  logic                     in_valid     = 1'b0;
  logic                     op           = OP_ALLOC;
  logic [OPC_W-1:0]         req_opcode   = '0;
  logic [SLOT_OUT_W-1:0]    release_slot = '0;
  logic                     out_ready    = 1'b0;
  logic                     cfg_ready;
  logic                     in_ready;
  logic                     out_valid;
  logic [STATUS_W-1:0]      status;
  logic [OWNER_W-1:0]       thread_index;
  logic [SLOT_OUT_W-1:0]    slot_index;
  int                       mismatches;
  int                       outstanding;
  logic [DEF_NUM_SLOTS-1:0] busy_map;
  int                       n_ok;
  int                       n_no_thread;
  int                       n_no_slot;
  int                       n_not_active;

  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               alloc_pct      = 50;
  int               sent           = 0;
  logic [OPC_W-1:0] phase_opc [CFG_REGS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  least_loaded_operator_dispatcher u_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .op, .req_opcode, .release_slot,
    .out_valid, .out_ready, .status, .thread_index, .slot_index
  );

  llod_dispatch_checker u_check (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .op, .req_opcode, .release_slot,
    .out_valid, .out_ready, .status, .thread_index, .slot_index,
    .mismatches, .outstanding, .busy_map,
    .n_ok, .n_no_thread, .n_no_slot, .n_not_active
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic write_opcodes(input logic [OPC_W-1:0] a, input logic [OPC_W-1:0] b,
                               input logic [OPC_W-1:0] c, input logic [OPC_W-1:0] d);
    logic [OPC_W-1:0] vals [CFG_REGS];
    vals = '{a, b, c, d};
    cfg_valid <= 1'b1;
    for (int i = 0; i < CFG_REGS; i++) begin
      cfg_index    <= CFG_IDX_W'(REG_THREAD0_OPCODE + i);
      cfg_data     <= vals[i];
      phase_opc[i]  = vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic push_request(input logic o, input logic [OPC_W-1:0] opc,
                              input logic [SLOT_OUT_W-1:0] rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    req_opcode   <= opc;
    release_slot <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SLOT_OUT_W-1:0] pick_busy_slot();
    int start;
    start = $urandom_range(DEF_NUM_SLOTS - 1);
    for (int k = 0; k < DEF_NUM_SLOTS; k++)
      if (busy_map[(start + k) % DEF_NUM_SLOTS]) return SLOT_OUT_W'((start + k) % DEF_NUM_SLOTS);
    return SLOT_OUT_W'(start);
  endfunction

  task automatic random_request();
    logic                  o;
    logic [OPC_W-1:0]      opc;
    logic [SLOT_OUT_W-1:0] rs;
    o   = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_RELEASE;
    opc = ($urandom_range(99) < 85) ? phase_opc[$urandom_range(CFG_REGS - 1)]
                                     : OPC_W'($urandom_range(255));
    rs  = ($urandom_range(99) < 85) ? pick_busy_slot() : SLOT_OUT_W'($urandom_range(63));
    push_request(o, opc, rs);
  endtask

  task automatic run_phase(input int idle, input int stall, input int alloc,
                           input logic [OPC_W-1:0] a, input logic [OPC_W-1:0] b,
                           input logic [OPC_W-1:0] c, input logic [OPC_W-1:0] d,
                           input int count);
    drain();
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    alloc_pct      = alloc;
    write_opcodes(a, b, c, d);
    repeat (count) random_request();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_opcodes(8'd5, 8'd5, 8'd9, 8'd255);
    push_request(OP_ALLOC, 8'd0, 6'd63);
    push_request(OP_ALLOC, 8'd77, 6'd0);
    push_request(OP_ALLOC, 8'd5, 6'd0);
    push_request(OP_ALLOC, 8'd5, 6'd0);
    push_request(OP_ALLOC, 8'd5, 6'd0);
    push_request(OP_ALLOC, 8'd9, 6'd0);
    push_request(OP_ALLOC, 8'd255, 6'd0);
    push_request(OP_RELEASE, 8'd0, 6'd1);
    push_request(OP_RELEASE, 8'd255, 6'd1);
    push_request(OP_RELEASE, 8'd0, 6'd63);
    push_request(OP_ALLOC, 8'd5, 6'd63);
    push_request(OP_RELEASE, 8'd0, 6'd0);
    push_request(OP_RELEASE, 8'd0, 6'd2);
    push_request(OP_RELEASE, 8'd0, 6'd3);
    push_request(OP_RELEASE, 8'd0, 6'd4);
    push_request(OP_RELEASE, 8'd0, 6'd1);
    push_request(OP_RELEASE, 8'd0, 6'd1);

    run_phase(0, 0, 75, 8'd5, 8'd5, 8'd5, 8'd5, 125);
    run_phase(87, 0, 55, 8'd1, 8'd2, 8'd3, 8'd4, 125);
    run_phase(0, 87, 80, 8'd0, 8'd0, 8'd0, 8'd200, 125);
    run_phase(27, 27, 45, 8'd255, 8'd17, 8'd255, 8'd0, 125);
    run_phase(0, 0, 70, 8'd128, 8'd64, 8'd128, 8'd1, 125);
    run_phase(0, 0, 30, 8'd0, 8'd0, 8'd0, 8'd0, 125);
    drain();

    $display("Covered %0d requests across seven opcode settings and all idling modes.", sent);
    $display("Results: %0d ok, %0d no matching thread, %0d no free slot, %0d inactive release.",
             n_ok, n_no_thread, n_no_slot, n_not_active);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still pending.", outstanding);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/llod_pkg.sv
rtl/llod_thread_sel.sv
rtl/llod_slot_map.sv
rtl/least_loaded_operator_dispatcher.sv
tb/llod_dispatch_checker.sv
tb/least_loaded_operator_dispatcher_test.sv
